FILE: rtl/cpl_pkg.sv
// Package: character classes, trie node types and the fixed punctuator trie tables.
`timescale 1ns / 1ps

package cpl_pkg;

	localparam int unsigned CodePointWidth = 21;
	localparam int unsigned NodeWidth      = 6;
	localparam int unsigned TokenWidth     = 6;
	localparam int unsigned LengthWidth    = 3;

	typedef logic [NodeWidth-1:0]   node_id_t;
	typedef logic [TokenWidth-1:0]  token_id_t;
	typedef logic [LengthWidth-1:0] path_len_t;

	localparam node_id_t  RootNode  = '0;
	localparam path_len_t LengthMax = '1;

	// One class per character that appears in some punctuator.
	typedef enum logic [4:0] {
		CC_OTHER,
		CC_LBRACK, CC_RBRACK, CC_LPAREN, CC_RPAREN, CC_LBRACE, CC_RBRACE,
		CC_DOT, CC_MINUS, CC_GT, CC_PLUS, CC_AMP, CC_STAR, CC_TILDE,
		CC_BANG, CC_SLASH, CC_PERCENT, CC_LT, CC_EQ, CC_CARET, CC_PIPE,
		CC_QUEST, CC_COLON, CC_SEMI, CC_COMMA, CC_HASH
	} char_class_t;

	// One entry of the queue between classifier and trie walker.
	typedef struct packed {
		char_class_t cls;
		logic        final_char;
	} queue_entry_t;

	typedef struct packed {
		logic      hit;
		token_id_t code;
	} node_token_t;

	function automatic char_class_t classify(input logic [CodePointWidth-1:0] cp);
		char_class_t cls;
		unique case (cp)
			21'h00005B: cls = CC_LBRACK;
			21'h00005D: cls = CC_RBRACK;
			21'h000028: cls = CC_LPAREN;
			21'h000029: cls = CC_RPAREN;
			21'h00007B: cls = CC_LBRACE;
			21'h00007D: cls = CC_RBRACE;
			21'h00002E: cls = CC_DOT;
			21'h00002D: cls = CC_MINUS;
			21'h00003E: cls = CC_GT;
			21'h00002B: cls = CC_PLUS;
			21'h000026: cls = CC_AMP;
			21'h00002A: cls = CC_STAR;
			21'h00007E: cls = CC_TILDE;
			21'h000021: cls = CC_BANG;
			21'h00002F: cls = CC_SLASH;
			21'h000025: cls = CC_PERCENT;
			21'h00003C: cls = CC_LT;
			21'h00003D: cls = CC_EQ;
			21'h00005E: cls = CC_CARET;
			21'h00007C: cls = CC_PIPE;
			21'h00003F: cls = CC_QUEST;
			21'h00003A: cls = CC_COLON;
			21'h00003B: cls = CC_SEMI;
			21'h00002C: cls = CC_COMMA;
			21'h000023: cls = CC_HASH;
			default:    cls = CC_OTHER;
		endcase
		return cls;
	endfunction

	// Child of a node along one character class; RootNode means no edge.
	function automatic node_id_t child_of(input node_id_t node, input char_class_t cls);
		node_id_t nxt;
		nxt = RootNode;
		unique case (node)
			6'd0: begin
				unique case (cls)
					CC_LBRACK:  nxt = 6'd1;
					CC_RBRACK:  nxt = 6'd2;
					CC_LPAREN:  nxt = 6'd3;
					CC_RPAREN:  nxt = 6'd4;
					CC_LBRACE:  nxt = 6'd5;
					CC_RBRACE:  nxt = 6'd6;
					CC_DOT:     nxt = 6'd7;
					CC_MINUS:   nxt = 6'd8;
					CC_PLUS:    nxt = 6'd10;
					CC_AMP:     nxt = 6'd13;
					CC_STAR:    nxt = 6'd14;
					CC_TILDE:   nxt = 6'd15;
					CC_BANG:    nxt = 6'd16;
					CC_SLASH:   nxt = 6'd17;
					CC_PERCENT: nxt = 6'd18;
					CC_LT:      nxt = 6'd19;
					CC_GT:      nxt = 6'd21;
					CC_EQ:      nxt = 6'd25;
					CC_CARET:   nxt = 6'd28;
					CC_PIPE:    nxt = 6'd29;
					CC_QUEST:   nxt = 6'd32;
					CC_COLON:   nxt = 6'd33;
					CC_SEMI:    nxt = 6'd34;
					CC_COMMA:   nxt = 6'd47;
					CC_HASH:    nxt = 6'd48;
					default:    nxt = RootNode;
				endcase
			end
			6'd7:  if (cls == CC_DOT) nxt = 6'd35;
			6'd35: if (cls == CC_DOT) nxt = 6'd36;
			6'd8: begin
				if (cls == CC_GT)    nxt = 6'd9;
				if (cls == CC_MINUS) nxt = 6'd12;
				if (cls == CC_EQ)    nxt = 6'd41;
			end
			6'd10: begin
				if (cls == CC_PLUS) nxt = 6'd11;
				if (cls == CC_EQ)   nxt = 6'd40;
			end
			6'd13: begin
				if (cls == CC_AMP) nxt = 6'd30;
				if (cls == CC_EQ)  nxt = 6'd44;
			end
			6'd14: if (cls == CC_EQ) nxt = 6'd37;
			6'd16: if (cls == CC_EQ) nxt = 6'd27;
			6'd17: if (cls == CC_EQ) nxt = 6'd38;
			6'd18: begin
				if (cls == CC_EQ)    nxt = 6'd39;
				if (cls == CC_GT)    nxt = 6'd53;
				if (cls == CC_COLON) nxt = 6'd54;
			end
			6'd54: if (cls == CC_PERCENT) nxt = 6'd55;
			6'd55: if (cls == CC_COLON) nxt = 6'd56;
			6'd19: begin
				if (cls == CC_LT)      nxt = 6'd20;
				if (cls == CC_EQ)      nxt = 6'd23;
				if (cls == CC_COLON)   nxt = 6'd50;
				if (cls == CC_PERCENT) nxt = 6'd52;
			end
			6'd20: if (cls == CC_EQ) nxt = 6'd42;
			6'd21: begin
				if (cls == CC_GT) nxt = 6'd22;
				if (cls == CC_EQ) nxt = 6'd24;
			end
			6'd22: if (cls == CC_EQ) nxt = 6'd43;
			6'd25: if (cls == CC_EQ) nxt = 6'd26;
			6'd28: if (cls == CC_EQ) nxt = 6'd45;
			6'd29: begin
				if (cls == CC_PIPE) nxt = 6'd31;
				if (cls == CC_EQ)   nxt = 6'd46;
			end
			6'd33: if (cls == CC_GT) nxt = 6'd51;
			6'd48: if (cls == CC_HASH) nxt = 6'd49;
			default: nxt = RootNode;
		endcase
		return nxt;
	endfunction

	// Token that ends at a node; the root and pure prefixes carry none.
	function automatic node_token_t token_of(input node_id_t node);
		node_token_t t;
		t.hit = 1'b1;
		unique case (node)
			6'd1:  t.code = 6'd0;
			6'd2:  t.code = 6'd1;
			6'd3:  t.code = 6'd2;
			6'd4:  t.code = 6'd3;
			6'd5:  t.code = 6'd4;
			6'd6:  t.code = 6'd5;
			6'd7:  t.code = 6'd6;
			6'd8:  t.code = 6'd13;
			6'd9:  t.code = 6'd7;
			6'd10: t.code = 6'd12;
			6'd11: t.code = 6'd8;
			6'd12: t.code = 6'd9;
			6'd13: t.code = 6'd10;
			6'd14: t.code = 6'd11;
			6'd15: t.code = 6'd14;
			6'd16: t.code = 6'd15;
			6'd17: t.code = 6'd16;
			6'd18: t.code = 6'd17;
			6'd19: t.code = 6'd20;
			6'd20: t.code = 6'd18;
			6'd21: t.code = 6'd21;
			6'd22: t.code = 6'd19;
			6'd23: t.code = 6'd22;
			6'd24: t.code = 6'd23;
			6'd25: t.code = 6'd34;
			6'd26: t.code = 6'd24;
			6'd27: t.code = 6'd25;
			6'd28: t.code = 6'd26;
			6'd29: t.code = 6'd27;
			6'd30: t.code = 6'd28;
			6'd31: t.code = 6'd29;
			6'd32: t.code = 6'd30;
			6'd33: t.code = 6'd31;
			6'd34: t.code = 6'd32;
			6'd36: t.code = 6'd33;
			6'd37: t.code = 6'd35;
			6'd38: t.code = 6'd36;
			6'd39: t.code = 6'd37;
			6'd40: t.code = 6'd38;
			6'd41: t.code = 6'd39;
			6'd42: t.code = 6'd40;
			6'd43: t.code = 6'd41;
			6'd44: t.code = 6'd42;
			6'd45: t.code = 6'd43;
			6'd46: t.code = 6'd44;
			6'd47: t.code = 6'd45;
			6'd48: t.code = 6'd46;
			6'd49: t.code = 6'd47;
			6'd50: t.code = 6'd48;
			6'd51: t.code = 6'd49;
			6'd52: t.code = 6'd50;
			6'd53: t.code = 6'd51;
			6'd54: t.code = 6'd52;
			6'd56: t.code = 6'd53;
			default: begin
				t.hit  = 1'b0;
				t.code = '0;
			end
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/cpl_front.sv
// Front stage: accept characters, classify them and push them into the queue.
`timescale 1ns / 1ps

module cpl_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [cpl_pkg::CodePointWidth-1:0]    code_point,
	input  logic                                  final_char,
	output logic                                  push,
	output cpl_pkg::queue_entry_t                 push_entry,
	input  logic                                  queue_full
);
	import cpl_pkg::*;

	logic         valid_s1;
	queue_entry_t entry_s1;

	// Hold the staged request while the queue is full.
	assign in_stall   = valid_s1 & queue_full;
	assign push       = valid_s1 & ~queue_full;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			entry_s1.cls        <= classify(code_point);
			entry_s1.final_char <= final_char;
		end
	end

endmodule

FILE: rtl/cpl_queue.sv
// Short FIFO of classified characters between front and trie walker.
`timescale 1ns / 1ps

module cpl_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cpl_pkg::queue_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output cpl_pkg::queue_entry_t head
);
	import cpl_pkg::*;

	localparam int unsigned PtrWidth   = $clog2(DEPTH);
	localparam int unsigned CountWidth = $clog2(DEPTH + 1);
	localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(DEPTH - 1);
	localparam logic [CountWidth-1:0] CountFull = CountWidth'(DEPTH);

	queue_entry_t            slots_q [DEPTH];
	logic [PtrWidth-1:0]     wr_ptr_q;
	logic [PtrWidth-1:0]     rd_ptr_q;
	logic [CountWidth-1:0]   count_q;

	assign full      = (count_q == CountFull);
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountFull)
		else $error("queue count beyond depth");

endmodule

FILE: rtl/cpl_back.sv
// Back stage: walk the punctuator trie and register one result per finished token.
`timescale 1ns / 1ps

module cpl_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                not_empty,
	input  cpl_pkg::queue_entry_t               head,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                status,
	output logic [cpl_pkg::TokenWidth-1:0]      token_code,
	output logic [cpl_pkg::LengthWidth-1:0]     token_length,
	output logic                                char_taken
);
	import cpl_pkg::*;

	node_id_t    node_q;
	path_len_t   len_q;
	logic        out_valid_q;
	logic        status_q;
	token_id_t   code_q;
	path_len_t   length_q;
	logic        taken_q;

	node_id_t    child;
	logic        path_grows;
	path_len_t   len_next;
	logic        emit;
	node_id_t    emit_node;
	path_len_t   emit_len;
	node_token_t emit_tok;

	// Take the head whenever the output register is free or being drained.
	assign pop = not_empty & (~out_valid_q | ~out_stall);

	always_comb begin
		child      = child_of(node_q, head.cls);
		path_grows = (child != RootNode);
		len_next   = (len_q == LengthMax) ? LengthMax : len_q + 1'b1;
		emit       = ~path_grows | head.final_char;
		emit_node  = path_grows ? child : node_q;
		emit_len   = path_grows ? len_next : len_q;
		emit_tok   = token_of(emit_node);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q      <= RootNode;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (emit) begin
					node_q      <= RootNode;
					len_q       <= '0;
					out_valid_q <= 1'b1;
				end else begin
					node_q <= child;
					len_q  <= len_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			status_q <= ~emit_tok.hit;
			code_q   <= emit_tok.code;
			length_q <= emit_tok.hit ? emit_len : '0;
			taken_q  <= path_grows;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign token_code   = code_q;
	assign token_length = length_q;
	assign char_taken   = taken_q;

	a_root_has_no_path: assert property (@(posedge clk) disable iff (!arst_n)
		(node_q == RootNode) |-> (len_q == '0))
		else $error("path length nonzero at root");

	a_match_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !status_q) |-> (length_q != '0))
		else $error("matched token with zero length");

	a_miss_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (code_q == '0 && length_q == '0))
		else $error("no-match result carries token fields");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(code_q) && $stable(length_q)))
		else $error("stalled result changed");

endmodule

FILE: rtl/c_punctuator_longest_match.sv
// Top level: C punctuator longest-match recognizer, one character per request.
`timescale 1ns / 1ps

// Recognizes C punctuators (54 kinds, digraphs included) from a stream of code
// points, one character per request. Each character walks one edge of a fixed
// trie; a result request appears when a character does not extend the path
// (that character is not consumed, char_taken = 0, and the source must present
// it again) or when the final character of the text arrives. A path that ends
// on a node which is only a prefix, such as "..", reports no match. Throughput
// is one character per clock while neither side stalls, set by the trie step
// in the walker, whose node register feeds back into the next step. An accepted
// character reaches its result through the classifier stage, the queue and the
// result register. The queue lets the input keep flowing while a result waits
// on a stalled output.
module c_punctuator_longest_match #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cpl_pkg::CodePointWidth-1:0]  code_point,
	input  logic                                final_char,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                status,
	output logic [cpl_pkg::TokenWidth-1:0]      token_code,
	output logic [cpl_pkg::LengthWidth-1:0]     token_length,
	output logic                                char_taken
);
	import cpl_pkg::*;

	logic         push;
	queue_entry_t push_entry;
	logic         queue_full;
	logic         pop;
	logic         not_empty;
	queue_entry_t head;

	// Classify each character into a small class code and stage it.
	cpl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_point (code_point),
		.final_char (final_char),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	// Decouple classification from the trie walk.
	cpl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	// Advance through the trie and register each finished token.
	cpl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.token_code   (token_code),
		.token_length (token_length),
		.char_taken   (char_taken)
	);

endmodule

FILE: bench/tb_c_punctuator_longest_match.sv
// Testbench: C punctuator longest-match recognizer, checked against a trie predictor.
`timescale 1ns / 1ps

module tb_c_punctuator_longest_match;

	localparam int CpW       = cpl_pkg::CodePointWidth;
	localparam int NoToken   = -1;
	localparam int ItemTotal = 1300;
	localparam int HoldOff   = 400;
	localparam int TailWait  = 20;
	localparam int CycleCap  = 200000;

	// One result request as the block reports it.
	typedef struct packed {
		logic                status;
		cpl_pkg::token_id_t  code;
		cpl_pkg::path_len_t  len;
		logic                taken;
	} token_result_t;

	// Receiver behavior for one stretch of cycles.
	typedef enum int {
		SINK_FLOW,
		SINK_LIGHT,
		SINK_HEAVY
	} sink_mode_t;

	// Trie walker mirroring the block, plus the queue of tokens still owed.
	class punct_scoreboard;
		string           punct_list [54];
		logic [CpW-1:0]  edge_ch [64];
		int              edge_par [64];
		int              node_tok [64];
		int              node_count;
		int              cur_node;
		int              path_len;
		token_result_t   token_q [$];
		int              errors;

		function new();
			int node;
			int nxt;
			logic [CpW-1:0] c;
			punct_list = '{
				"[", "]", "(", ")", "{", "}", ".", "->", "++", "--",
				"&", "*", "+", "-", "~", "!", "/", "%", "<<", ">>",
				"<", ">", "<=", ">=", "==", "!=", "^", "|", "&&", "||",
				"?", ":", ";", "...", "=", "*=", "/=", "%=", "+=", "-=",
				"<<=", ">>=", "&=", "^=", "|=", ",", "#", "##", "<:", ":>",
				"<%", "%>", "%:", "%:%:"
			};
			node_count  = 1;
			edge_ch[0]  = '0;
			edge_par[0] = 0;
			node_tok[0] = NoToken;
			// Insert every punctuator in table order; node numbers follow insertion.
			for (int i = 0; i < 54; i++) begin
				node = 0;
				for (int j = 0; j < punct_list[i].len(); j++) begin
					c   = {13'd0, punct_list[i][j]};
					nxt = child_of_node(node, c);
					if (nxt == 0) begin
						nxt           = node_count;
						node_count++;
						edge_ch[nxt]  = c;
						edge_par[nxt] = node;
						node_tok[nxt] = NoToken;
					end
					node = nxt;
				end
				node_tok[node] = i;
			end
			cur_node = 0;
			path_len = 0;
			errors   = 0;
		endfunction

		function int child_of_node(int node, logic [CpW-1:0] c);
			for (int k = 1; k < node_count; k++)
				if (edge_par[k] == node && edge_ch[k] == c)
					return k;
			return 0;
		endfunction

		// Queue the token for a node and fall back to the root.
		function void push_token(int node, int len, bit taken);
			token_result_t r;
			r.taken = taken;
			if (node_tok[node] == NoToken) begin
				r.status = 1'b1;
				r.code   = '0;
				r.len    = '0;
			end else begin
				r.status = 1'b0;
				r.code   = cpl_pkg::token_id_t'(node_tok[node]);
				r.len    = cpl_pkg::path_len_t'(len);
			end
			token_q.push_back(r);
			cur_node = 0;
			path_len = 0;
		endfunction

		// Advance on an accepted character; return 1 when the source must resend it.
		function bit note_request(logic [CpW-1:0] cp, bit fin);
			int child;
			int len;
			int from;
			child = child_of_node(cur_node, cp);
			if (child != 0) begin
				len = (path_len < 7) ? path_len + 1 : 7;
				if (!fin) begin
					cur_node = child;
					path_len = len;
				end else begin
					push_token(child, len, 1'b1);
				end
				return 1'b0;
			end
			from = cur_node;
			push_token(cur_node, path_len, 1'b0);
			// A character refused at the root is not a punctuator: drop it.
			return from != 0;
		endfunction

		function void check_result(token_result_t got);
			token_result_t exp;
			if (token_q.size() == 0) begin
				$error("unexpected result: status %0d token_code %0d token_length %0d",
					got.status, got.code, got.len);
				errors++;
				return;
			end
			exp = token_q.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				errors++;
			end
			if (got.code !== exp.code) begin
				$error("token_code: expected %0d, actual %0d", exp.code, got.code);
				errors++;
			end
			if (got.len !== exp.len) begin
				$error("token_length: expected %0d, actual %0d", exp.len, got.len);
				errors++;
			end
			if (got.taken !== exp.taken) begin
				$error("char_taken: expected %0d, actual %0d", exp.taken, got.taken);
				errors++;
			end
		endfunction

		function int pending();
			return token_q.size();
		endfunction
	endclass

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic [CpW-1:0]                code_point   = '0;
	logic                          final_char   = 1'b0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic                          status;
	logic [cpl_pkg::TokenWidth-1:0]  token_code;
	logic [cpl_pkg::LengthWidth-1:0] token_length;
	logic                          char_taken;

	punct_scoreboard sb = new();

	int    items_sent     = 0;
	int    burst_left     = 0;
	int    cycle_count    = 0;
	bit    long_hold_req  = 1'b0;
	bit    long_hold_done = 1'b0;
	string broken_list [4];

	c_punctuator_longest_match dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.code_point   (code_point),
		.final_char   (final_char),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.token_code   (token_code),
		.token_length (token_length),
		.char_taken   (char_taken)
	);

	always #4 clk = ~clk;

	// Bound the run: a hung handshake ends here instead of spinning forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleCap) begin
			$display("FAIL c_punctuator_longest_match");
			$finish;
		end
	end

	// Check every result request the block hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{status, token_code, token_length, char_taken});
	end

	// Receiver: stretches of free flow, light and heavy stalling, plus one long
	// hold-off so the queue fills and the block must stall its input.
	initial begin
		sink_mode_t mode;
		int         seg;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold_req && !long_hold_done) begin
				out_stall <= 1'b1;
				repeat (HoldOff) @(posedge clk);
				long_hold_done = 1'b1;
			end
			mode = sink_mode_t'($urandom_range(0, 2));
			seg  = $urandom_range(20, 120);
			repeat (seg) begin
				case (mode)
					SINK_FLOW:  out_stall <= 1'b0;
					SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					default:    out_stall <= ($urandom_range(0, 9) < 7);
				endcase
				@(posedge clk);
			end
		end
	end

	// Drop valid and hold it low for a number of cycles.
	task automatic hold_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offer one character and wait for the request to be taken. Pacing comes
	// first: bursts of random length, each usually preceded by a short gap.
	task automatic put_char(input logic [CpW-1:0] cp, input logic fin, output bit resend);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 9) < 7)
				hold_input($urandom_range(1, 6));
		end
		burst_left--;
		in_valid   <= 1'b1;
		code_point <= cp;
		final_char <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		resend = sb.note_request(cp, fin);
		items_sent++;
	endtask

	// Send a character as a tokenizer would: a refused character is sent again
	// as the start of the next token.
	task automatic send_char(input logic [CpW-1:0] cp, input logic fin);
		bit again;
		put_char(cp, fin, again);
		if (again)
			put_char(cp, fin, again);
	endtask

	task automatic send_text(input string s, input logic fin_last);
		for (int j = 0; j < s.len(); j++)
			send_char({13'd0, s[j]}, fin_last && (j == s.len() - 1));
	endtask

	// Stop offering and wait until every owed token has come back.
	task automatic drain_tokens();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// One random token: mostly well-formed punctuators, some broken prefixes,
	// some plain ASCII and some arbitrary 21-bit code points.
	task automatic send_random_token();
		int    pick;
		string s;
		logic  fin;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			s = sb.punct_list[$urandom_range(0, 53)];
			for (int j = 0; j < s.len(); j++) begin
				fin = ($urandom_range(0, 15) == 0) ||
					(j == s.len() - 1 && $urandom_range(0, 7) == 0);
				send_char({13'd0, s[j]}, fin);
			end
			// Separate from the next token now and then; otherwise let them run together.
			if ($urandom_range(0, 9) < 4)
				send_char(CpW'($urandom_range(8'h61, 8'h7A)), $urandom_range(0, 15) == 0);
		end else if (pick < 80) begin
			send_text(broken_list[$urandom_range(0, 3)], $urandom_range(0, 7) == 0);
		end else if (pick < 90) begin
			send_char(CpW'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
		end else begin
			send_char(CpW'($urandom_range(0, 21'h1FFFFF)), $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		broken_list = '{"..", "%:%", "..a", "<:>"};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes and the corner cases of the trie walk.
		send_char('0, 1'b0);                 // nothing at the root
		send_char(CpW'(21'h10FFFF), 1'b0);   // highest code point
		send_char('1, 1'b1);                 // beyond the code point range, final
		send_text("->", 1'b1);               // extending final character
		send_text("+a", 1'b0);               // refused character after a token
		send_text("..x", 1'b0);              // path ends on a pure prefix
		send_text("%:%x", 1'b0);             // no backtracking to "%:"
		send_text("%:%:", 1'b1);             // longest punctuator, final
		send_text("<<=", 1'b0);
		send_text("+", 1'b1);                // refused final character, resent
		send_text("...", 1'b0);
		send_char(CpW'(8'h78), 1'b1);
		send_text("*q", 1'b1);               // refused final character at the root
		drain_tokens();

		// Random: ask for the long hold-off while requests keep coming.
		long_hold_req = 1'b1;
		while (items_sent < ItemTotal) begin
			send_random_token();
			if (items_sent >= ItemTotal / 2 && items_sent < ItemTotal / 2 + 6)
				drain_tokens();
		end
		send_char(CpW'(8'h3B), 1'b1);         // flush the walker back to the root
		drain_tokens();
		repeat (TailWait) @(posedge clk);

		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("PASS c_punctuator_longest_match");
		else
			$display("FAIL c_punctuator_longest_match");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cpl_pkg.sv
rtl/cpl_front.sv
rtl/cpl_queue.sv
rtl/cpl_back.sv
rtl/c_punctuator_longest_match.sv
bench/tb_c_punctuator_longest_match.sv
